### rtl/core/hrue_pkg.sv
`timescale 1ns / 1ps

package hrue_pkg;

	// Parse phase of the short-item walker. Code 3 is never entered.
	typedef enum logic [1:0] {
		PH_TAG  = 2'd0,
		PH_DATA = 2'd1,
		PH_DONE = 2'd2
	} phase_t;

	localparam logic [7:0] SIZE_MASK      = 8'h03;
	localparam logic [1:0] SIZE_CODE_FOUR = 2'd3;
	localparam logic [7:0] TAG_PAGE_8     = 8'h05;
	localparam logic [7:0] TAG_PAGE_16    = 8'h06;
	localparam logic [7:0] TAG_USAGE_8    = 8'h09;
	localparam logic [7:0] TAG_USAGE_16   = 8'h0A;

	typedef struct packed {
		logic [15:0] page_id;
		logic [15:0] usage;
		logic        usage_found;
	} result_t;

endpackage

### rtl/core/hrue_in_if.sv
`timescale 1ns / 1ps

interface hrue_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_descriptor;

	modport source (output valid, output data_byte, output end_of_descriptor, input ready);
	modport sink (input valid, input data_byte, input end_of_descriptor, output ready);
endinterface

### rtl/core/hrue_out_if.sv
`timescale 1ns / 1ps

interface hrue_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] page_id;
	logic [15:0] usage;
	logic        usage_found;

	modport source (output valid, output page_id, output usage, output usage_found,
		input ready);
	modport sink (input valid, input page_id, input usage, input usage_found,
		output ready);
endinterface

### rtl/core/hid_report_usage_extractor.sv
`timescale 1ns / 1ps

// Channel  Dir  Beat payload                              Beats
// desc     in   data_byte[7:0], end_of_descriptor          one per descriptor byte
// res      out  page_id[15:0], usage[15:0], usage_found    one per descriptor
//
// One byte enters per cycle unless a stalled final byte holds the input register.
// A byte sits in the input register, where the walker updates its state;
// a final byte loads the result register at the edge that moves it on, so the
// result is valid once the final byte has left the input register.
// Reset clears both valid flags and the parse state; nothing else needs it.
// A stalled result holds back a final byte waiting behind it, and the input
// with it; other bytes keep flowing into the walker.
module hid_report_usage_extractor (
	input  logic       clk,
	input  logic       arst_n,
	hrue_in_if.sink    desc,
	hrue_out_if.source res
);
	import hrue_pkg::*;

	// Input register
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;

	// Result register
	logic    out_valid_q;
	result_t out_q;
	result_t parse_result;

	logic advance;

	// A byte in the input register moves on unless it is a final byte and
	// the result register is still occupied by an untaken result.
	assign advance    = valid_s1 && (!last_s1 || !out_valid_q || res.ready);
	assign desc.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (desc.ready) begin
			valid_s1 <= desc.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (desc.ready && desc.valid) begin
			data_s1 <= desc.data_byte;
			last_s1 <= desc.end_of_descriptor;
		end
	end

	hrue_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (data_s1),
		.last      (last_s1),
		.result    (parse_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_q <= parse_result;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.page_id     = out_q.page_id;
	assign res.usage       = out_q.usage;
	assign res.usage_found = out_q.usage_found;

`ifndef SYNTHESIS
	// A final byte that was let through must show up as a result next cycle.
	a_last_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> out_valid_q)
		else $error("final beat did not load the result register");

	// A final byte never overwrites a result that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1 && out_valid_q && !res.ready) |-> !advance)
		else $error("result overwritten while stalled");

	// No usage value without the found flag.
	a_usage_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.usage_found) |-> (out_q.usage == 16'h0000))
		else $error("usage nonzero without usage_found");
`endif

endmodule

### rtl/core/hrue_parser.sv
`timescale 1ns / 1ps

// Short-item walker. Holds the parse state, advances it by one byte when
// step is high, or clears it on a final byte, and shows the result after that byte.
module hrue_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        data_byte,
	input  logic              last,
	output hrue_pkg::result_t result
);
	import hrue_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  tag_q, tag_d;
	logic [2:0]  left_q, left_d;
	logic [2:0]  pos_q, pos_d;
	logic [7:0]  low_q, low_d;
	logic [7:0]  high_q, high_d;
	logic [15:0] page_q, page_d;
	logic [15:0] usage_q, usage_d;
	logic        finish;

	// Next state
	always_comb begin
		phase_d = phase_q;
		tag_d   = tag_q;
		left_d  = left_q;
		pos_d   = pos_q;
		low_d   = low_q;
		high_d  = high_q;
		page_d  = page_q;
		usage_d = usage_q;
		finish  = 1'b0;
		unique case (phase_q)
			PH_TAG: begin
				tag_d  = data_byte;
				low_d  = 8'h00;
				high_d = 8'h00;
				pos_d  = 3'd0;
				if ((data_byte[1:0]) == SIZE_CODE_FOUR) begin
					left_d = 3'd4;
				end else begin
					left_d = {1'b0, data_byte[1:0]};
				end
				if ((data_byte & SIZE_MASK) == 8'h00) begin
					finish = 1'b1;
				end else begin
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				if (pos_q == 3'd0) begin
					low_d = data_byte;
				end else if (pos_q == 3'd1) begin
					high_d = data_byte;
				end
				pos_d = pos_q + 3'd1;
				if (left_q != 3'd0) begin
					left_d = left_q - 3'd1;
				end
				finish = (left_d == 3'd0);
			end
			default: begin
			end
		endcase
		if (finish) begin
			phase_d = PH_TAG;
			unique case (tag_d)
				TAG_PAGE_8: begin
					page_d = {8'h00, low_d};
				end
				TAG_PAGE_16: begin
					page_d = {high_d, low_d};
				end
				TAG_USAGE_8: begin
					usage_d = {8'h00, low_d};
					phase_d = PH_DONE;
				end
				TAG_USAGE_16: begin
					usage_d = {high_d, low_d};
					phase_d = PH_DONE;
				end
				default: begin
				end
			endcase
		end
	end

	// Result as it stands after this byte
	always_comb begin
		result.page_id     = page_d;
		result.usage_found = (phase_d == PH_DONE);
		result.usage       = (phase_d == PH_DONE) ? usage_d : 16'h0000;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG;
			tag_q   <= 8'h00;
			left_q  <= 3'd0;
			pos_q   <= 3'd0;
			low_q   <= 8'h00;
			high_q  <= 8'h00;
			page_q  <= 16'h0000;
			usage_q <= 16'h0000;
		end else if (step) begin
			if (last) begin
				phase_q <= PH_TAG;
				tag_q   <= 8'h00;
				left_q  <= 3'd0;
				pos_q   <= 3'd0;
				low_q   <= 8'h00;
				high_q  <= 8'h00;
				page_q  <= 16'h0000;
				usage_q <= 16'h0000;
			end else begin
				phase_q <= phase_d;
				tag_q   <= tag_d;
				left_q  <= left_d;
				pos_q   <= pos_d;
				low_q   <= low_d;
				high_q  <= high_d;
				page_q  <= page_d;
				usage_q <= usage_d;
			end
		end
	end

endmodule
